// ===== rtl/tqgm_pkg.sv =====
// Shared types and codes for the two-queue group matcher.
// No dependencies.
package tqgm_pkg;
   localparam logic [1:0] OP_JOIN   = 2'd0;
   localparam logic [1:0] OP_CANCEL = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;
   localparam logic [1:0] OP_POP    = 2'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_WAITING   = 3'd1;
   localparam logic [2:0] ST_BAD_MODE  = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_TOO_FEW   = 3'd4;
   localparam logic [2:0] ST_FULL      = 3'd5;

   localparam logic [2:0] MODE_TRIO = 3'd3;
   localparam logic [2:0] MODE_QUAD = 3'd4;

   typedef struct packed {
      logic [1:0]  operation;
      logic [63:0] member_id;
      logic [2:0]  group_mode;
   } cmd_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] matched_id;
      logic        is_waiting;
      logic        last;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_DECIDE, S_MOVE, S_POP, S_EMIT
   } state_type;
endpackage

// ===== rtl/two_queue_group_matcher.sv =====
// Channel | dir | payload
// req_    | in  | tdata: operation[1:0], member_id[65:2], group_mode[68:66]
// rsp_    | out | tdata: status[2:0], matched_id[66:3], is_waiting[67]; tlast: last
// Join, query and cancel scan both queues, one entry a cycle, before the result;
// a cancel hit adds a compaction pass after the result.
// A pop checks the count, sends one member beat at a time, then runs a pass over the
// remaining entries.
// The scan and compaction loops run on the single-read id memories.
// Reset clears both counts; memories need no clearing. A stalled rsp_ holds the
// back end while the front queue keeps taking up to two beats.
// Depends on tqgm_pkg, tqgm_cmd_queue, tqgm_engine.
module two_queue_group_matcher #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // operation, member_id, group_mode, zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // status, matched_id, is_waiting, zero fill
   output logic        rsp_tlast
);
   import tqgm_pkg::*;
   cmd_type in_cmd, q_cmd;
   rsp_type r;
   logic    q_valid, q_ready;

   assign in_cmd = '{operation: req_tdata[1:0], member_id: req_tdata[65:2],
                     group_mode: req_tdata[68:66]};

   tqgm_cmd_queue u_queue (
      .clock, .reset, .wr_valid(req_tvalid), .wr_ready(req_tready), .wr_data(in_cmd),
      .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
   );

   tqgm_engine #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_engine (
      .clock, .reset, .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(r)
   );

   assign rsp_tdata = {4'd0, r.is_waiting, r.matched_id, r.status};
   assign rsp_tlast = r.last;
endmodule

// ===== rtl/tqgm_cmd_queue.sv =====
// Short command queue between front and back ends.
// Depends on tqgm_pkg.
module tqgm_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  tqgm_pkg::cmd_type wr_data,
   output logic             rd_valid,
   input  logic             rd_ready,
   output tqgm_pkg::cmd_type rd_data
);
   import tqgm_pkg::*;
   cmd_type     slot_ff [2];
   logic        wp_ff, rp_ff, wp_in, rp_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push, pop;

   assign wr_ready = cnt_ff != 2'd2;
   assign rd_valid = cnt_ff != 2'd0;
   assign rd_data  = slot_ff[rp_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
      if (push) slot_ff[wp_ff] <= wr_data;
   end
endmodule

// ===== rtl/tqgm_engine.sv =====
// Back end: two id memories, scan, compaction and result output register.
// Depends on tqgm_pkg.
module tqgm_engine #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  tqgm_pkg::cmd_type cmd,
   output logic              out_valid,
   input  logic              out_ready,
   output tqgm_pkg::rsp_type out_data
);
   import tqgm_pkg::*;
   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [63:0] mem_t [QUEUE_DEPTH];
   logic [63:0] mem_q [QUEUE_DEPTH];
   logic [63:0] rd_t_ff, rd_q_ff;

   state_type   st_ff, st_in;
   cmd_type     c_ff;
   logic [CW-1:0] tcnt_ff, qcnt_ff, tcnt_in, qcnt_in;
   logic [CW-1:0] idx_ff, idx_in;     // read index
   logic [CW-1:0] wr_ff, wr_in;       // compaction write index
   logic        rv_ff, rv_in;         // read data valid for idx_ff-1
   logic        hit_t_ff, hit_q_ff, hit_t_in, hit_q_in;
   logic [2:0]  emit_ff, emit_in;
   logic        ov_ff, ov_in;
   rsp_type     od_ff, od_in;
   logic        sel_q_ff, sel_q_in;   // queue under move/pop
   logic        we_t, we_q;
   logic [AW-1:0] wa;
   logic [63:0] wd;
   logic [CW-1:0] need, cur_cnt, scan_max;
   logic [AW-1:0] ra;
   logic        rd_en;                // hold read data while a member beat waits
   logic        mode_ok, mode_q;
   logic        out_free;

   assign out_free  = !ov_ff || out_ready;
   assign cmd_ready = (st_ff == S_IDLE);
   assign out_valid = ov_ff;
   assign out_data  = od_ff;
   assign mode_q    = c_ff.group_mode == MODE_QUAD;
   assign mode_ok   = c_ff.group_mode == MODE_TRIO || mode_q;
   assign need      = mode_q ? CW'(4) : CW'(3);
   assign cur_cnt   = sel_q_ff ? qcnt_ff : tcnt_ff;
   assign scan_max  = (tcnt_ff > qcnt_ff) ? tcnt_ff : qcnt_ff;
   assign ra        = idx_ff[AW-1:0];
   assign rd_en     = !(st_ff == S_EMIT && !out_free);

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         S_IDLE:   if (cmd_valid) st_in = (cmd.operation == OP_POP) ? S_POP : S_SCAN;
         S_SCAN:   if (!rv_ff && idx_ff >= scan_max) st_in = S_DECIDE;
         S_DECIDE: if (out_free) begin
            st_in = S_IDLE;
            if (c_ff.operation == OP_CANCEL && (hit_t_ff || hit_q_ff)) st_in = S_MOVE;
         end
         S_MOVE:   if (!rv_ff && idx_ff >= cur_cnt) st_in = S_IDLE;
         S_POP:    if (out_free) begin
            if (!mode_ok || cur_cnt < need) st_in = S_IDLE;
            else st_in = S_EMIT;
         end
         S_EMIT:   if (out_free && rv_ff && emit_ff == need[2:0] - 3'd1)
            st_in = S_MOVE;
         default:  st_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      tcnt_in = tcnt_ff; qcnt_in = qcnt_ff;
      idx_in = idx_ff; wr_in = wr_ff; rv_in = 1'b0;
      hit_t_in = hit_t_ff; hit_q_in = hit_q_ff;
      emit_in = emit_ff; sel_q_in = sel_q_ff;
      ov_in = ov_ff && !out_ready; od_in = od_ff;
      we_t = 1'b0; we_q = 1'b0; wa = wr_ff[AW-1:0]; wd = 64'd0;
      unique case (st_ff)
         S_IDLE: begin
            idx_in = '0; wr_in = '0; hit_t_in = 1'b0; hit_q_in = 1'b0;
            emit_in = 3'd0;
            sel_q_in = cmd.group_mode == MODE_QUAD;
         end
         S_SCAN: begin
            if (idx_ff < scan_max) begin idx_in = idx_ff + CW'(1); rv_in = 1'b1; end
            if (rv_ff) begin
               if (idx_ff - CW'(1) < tcnt_ff && rd_t_ff == c_ff.member_id) hit_t_in = 1'b1;
               if (idx_ff - CW'(1) < qcnt_ff && rd_q_ff == c_ff.member_id) hit_q_in = 1'b1;
            end
         end
         S_DECIDE: if (out_free) begin
            ov_in = 1'b1;
            od_in = '{status: ST_OK, matched_id: 64'd0, is_waiting: 1'b0, last: 1'b1};
            idx_in = '0; wr_in = '0;
            sel_q_in = !hit_t_ff;
            unique case (c_ff.operation)
               OP_JOIN: begin
                  if (hit_t_ff || hit_q_ff) od_in.status = ST_WAITING;
                  else if (!mode_ok) od_in.status = ST_BAD_MODE;
                  else if ((mode_q ? qcnt_ff : tcnt_ff) >= CW'(QUEUE_DEPTH))
                     od_in.status = ST_FULL;
                  else begin
                     wa = mode_q ? qcnt_ff[AW-1:0] : tcnt_ff[AW-1:0];
                     wd = c_ff.member_id;
                     if (mode_q) begin we_q = 1'b1; qcnt_in = qcnt_ff + CW'(1); end
                     else begin we_t = 1'b1; tcnt_in = tcnt_ff + CW'(1); end
                  end
               end
               OP_CANCEL: if (!(hit_t_ff || hit_q_ff)) od_in.status = ST_NOT_FOUND;
               OP_QUERY:  od_in.is_waiting = hit_t_ff || hit_q_ff;
               default: ;
            endcase
         end
         S_POP: if (out_free) begin
            if (!mode_ok || cur_cnt < need) begin
               ov_in = 1'b1;
               od_in = '{status: (mode_ok ? ST_TOO_FEW : ST_BAD_MODE),
                         matched_id: 64'd0, is_waiting: 1'b0, last: 1'b1};
            end else begin
               idx_in = CW'(1); rv_in = 1'b1;
            end
         end
         S_EMIT: begin
            if (rv_ff && out_free) begin
               ov_in = 1'b1;
               od_in = '{status: ST_OK, matched_id: (sel_q_ff ? rd_q_ff : rd_t_ff),
                         is_waiting: 1'b0, last: (emit_ff == need[2:0] - 3'd1)};
               emit_in = emit_ff + 3'd1;
               if (emit_ff != need[2:0] - 3'd1) begin
                  idx_in = idx_ff + CW'(1); rv_in = 1'b1;
               end else begin
                  idx_in = need; wr_in = '0;
               end
            end else rv_in = rv_ff;
         end
         S_MOVE: begin
            // stream entries down, dropping cancelled matches (pop skips head)
            if (idx_ff < cur_cnt) begin idx_in = idx_ff + CW'(1); rv_in = 1'b1; end
            if (rv_ff && !(c_ff.operation == OP_CANCEL &&
                           (sel_q_ff ? rd_q_ff : rd_t_ff) == c_ff.member_id)) begin
               wd = sel_q_ff ? rd_q_ff : rd_t_ff;
               we_t = !sel_q_ff; we_q = sel_q_ff;
               wr_in = wr_ff + CW'(1);
            end
            if (!rv_ff && idx_ff >= cur_cnt) begin
               if (sel_q_ff) qcnt_in = wr_ff; else tcnt_in = wr_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; tcnt_ff <= '0; qcnt_ff <= '0; ov_ff <= 1'b0; rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in; tcnt_ff <= tcnt_in; qcnt_ff <= qcnt_in;
         ov_ff <= ov_in; rv_ff <= rv_in;
      end
      if (st_ff == S_IDLE && cmd_valid) c_ff <= cmd;
      idx_ff <= idx_in; wr_ff <= wr_in; hit_t_ff <= hit_t_in; hit_q_ff <= hit_q_in;
      emit_ff <= emit_in; sel_q_ff <= sel_q_in; od_ff <= od_in;
   end

   // id memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (we_t) mem_t[wa] <= wd;
      if (we_q) mem_q[wa] <= wd;
      if (rd_en) begin
         rd_t_ff <= mem_t[ra];
         rd_q_ff <= mem_q[ra];
      end
   end
endmodule

// ===== rtl/tqgm_checker.sv =====
// Port-level checks for the two-queue group matcher, bound to the top level.
// Depends on tqgm_pkg and the two_queue_group_matcher ports.
module tqgm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic        rsp_tlast
);
   import tqgm_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= ST_FULL)
      else $error("status code out of range");
   a_mid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[2:0] == ST_OK && !rsp_tdata[67])
      else $error("non-final beat must be a pop member");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != ST_OK |-> rsp_tdata[66:3] == 64'd0 && rsp_tlast)
      else $error("failing result carries an id");
endmodule

bind two_queue_group_matcher tqgm_checker u_checker (
   .clock, .reset, .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast
);
